/* rtl/cfgp_pkg.sv */
// Shared types, constants and the arctangent table for the cube face
// gnomonic projection pipeline. No dependencies.
package cfgp_pkg;

	// Angle resolution; CORDIC runs one micro-rotation per bit less one.
	localparam int ANGLE_BITS = 32;
	localparam int TAB_LEN    = 48;
	localparam int ITER       = (ANGLE_BITS - 1 > TAB_LEN) ? TAB_LEN : ANGLE_BITS - 1;

	// Datapath widths: W holds vectors and angles with headroom,
	// QB is the gnomonic quotient magnitude (up to 1.0 in Q2.30),
	// RW the restoring divider remainder.
	localparam int W  = 34;
	localparam int QB = 31;
	localparam int RW = 35;
	localparam int PW = 2 * W;

	localparam logic signed [W-1:0] Q30_ONE  = W'(64'sd1073741824);
	localparam logic signed [W-1:0] HALF_PI  = W'(64'sd1073741824);
	localparam logic signed [W-1:0] PI_ANGLE = W'(64'sd2147483648);
	localparam logic signed [W-1:0] CORDIC_K = W'(64'sd652032874);

	// Face codes
	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_PY = 3'd1;
	localparam logic [2:0] FACE_NX = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	// Sine/cosine rotation state for longitude and latitude together
	typedef struct packed {
		logic                func;
		logic                flip_lon;
		logic                flip_lat;
		logic signed [W-1:0] lon_x;
		logic signed [W-1:0] lon_y;
		logic signed [W-1:0] lon_z;
		logic signed [W-1:0] lat_x;
		logic signed [W-1:0] lat_y;
		logic signed [W-1:0] lat_z;
	} sc_data_t;

	// Restoring divider state for both face coordinates
	typedef struct packed {
		logic          func;
		logic [2:0]    face;
		logic          zero;
		logic          sx_neg;
		logic          sy_neg;
		logic [RW-1:0] rx;
		logic [RW-1:0] ry;
		logic [RW-1:0] sz;
		logic [QB-1:0] qx;
		logic [QB-1:0] qy;
	} dv_data_t;

	// Arctangent vectoring state for both coordinates
	typedef struct packed {
		logic                func;
		logic [2:0]          face;
		logic signed [W-1:0] gx;
		logic signed [W-1:0] gy;
		logic signed [W-1:0] ux;
		logic signed [W-1:0] uy;
		logic signed [W-1:0] uz;
		logic signed [W-1:0] vx;
		logic signed [W-1:0] vy;
		logic signed [W-1:0] vz;
	} at_data_t;

	// atan(2^-i) as a binary angle, 2^31 = pi
	function automatic logic signed [W-1:0] atan_tab(input int i);
		logic signed [W-1:0] r;
		case (i)
			0:  r = W'(64'sd536870912);
			1:  r = W'(64'sd316933406);
			2:  r = W'(64'sd167458907);
			3:  r = W'(64'sd85004756);
			4:  r = W'(64'sd42667331);
			5:  r = W'(64'sd21354465);
			6:  r = W'(64'sd10679838);
			7:  r = W'(64'sd5340245);
			8:  r = W'(64'sd2670163);
			9:  r = W'(64'sd1335087);
			10: r = W'(64'sd667544);
			11: r = W'(64'sd333772);
			12: r = W'(64'sd166886);
			13: r = W'(64'sd83443);
			14: r = W'(64'sd41722);
			15: r = W'(64'sd20861);
			16: r = W'(64'sd10430);
			17: r = W'(64'sd5215);
			18: r = W'(64'sd2608);
			19: r = W'(64'sd1304);
			20: r = W'(64'sd652);
			21: r = W'(64'sd326);
			22: r = W'(64'sd163);
			23: r = W'(64'sd81);
			24: r = W'(64'sd41);
			25: r = W'(64'sd20);
			26: r = W'(64'sd10);
			27: r = W'(64'sd5);
			28: r = W'(64'sd3);
			29: r = W'(64'sd1);
			30: r = W'(64'sd1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/cube_face_gnomonic_project_unit.sv */
// Cube face gnomonic projection: top level with the full datapath pipeline.
// Depends on cfgp_pkg.
//
// Projects a longitude/latitude point (binary angles, 2^31 = pi) onto the
// faces of a cube around the unit sphere and returns the face number with
// the two gnomonic Q2.30 coordinates, or their arctangents as binary angles
// when func is set. The datapath is fully pipelined: one transaction is
// accepted every cycle while in_stall is low. The pipeline is made of the
// three 31-stage chains: CORDIC sine/cosine, the one-bit-per-stage
// restoring divider and the CORDIC arctangent, plus seven single stages
// around them. An output register and a one-entry skid register sit at
// the end; in_stall rises only when both hold a result, and the whole
// pipeline then pauses.
module cube_face_gnomonic_project_unit
	import cfgp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic signed [31:0] longitude,
	input  logic signed [31:0] latitude,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [2:0]  face,
	output logic signed [31:0] coord_x,
	output logic signed [31:0] coord_y
);

	logic adv;

	sc_data_t sc_s [0:ITER];
	logic     sc_v [0:ITER];
	dv_data_t dv_s [0:QB];
	logic     dv_v [0:QB];
	at_data_t at_s [0:ITER];
	logic     at_v [0:ITER];

	logic signed [W-1:0]  clon_s1, slon_s1, clat_s1, slat_s1;
	logic                 func_s1, vld_s1;
	logic signed [PW-1:0] px_s2, py_s2;
	logic signed [W-1:0]  slat_s2;
	logic                 func_s2, vld_s2;
	logic signed [W-1:0]  xx_s3, yy_s3, zz_s3;
	logic                 func_s3, vld_s3;
	logic [2:0]           face_s4;
	logic signed [W-1:0]  sx_s4, sy_s4, sz_s4;
	logic                 func_s4, vld_s4;

	logic                 out_valid_q, skid_v_q;
	logic [2:0]           face_q, skid_face_q;
	logic signed [31:0]   cx_q, cy_q, skid_cx_q, skid_cy_q;

	// Whole pipeline moves unless the skid register is occupied
	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;

	// Angle folding into [-pi/2, pi/2]
	logic signed [W-1:0] lon_w, lat_w, lon_f, lat_f;
	logic                lon_flip, lat_flip;

	always_comb begin
		lon_w = W'(longitude);
		lat_w = W'(latitude);
		lon_flip = 1'b1;
		lat_flip = 1'b1;
		if (lon_w > HALF_PI) begin
			lon_f = lon_w - PI_ANGLE;
		end else if (lon_w < -HALF_PI) begin
			lon_f = lon_w + PI_ANGLE;
		end else begin
			lon_f = lon_w;
			lon_flip = 1'b0;
		end
		if (lat_w > HALF_PI) begin
			lat_f = lat_w - PI_ANGLE;
		end else if (lat_w < -HALF_PI) begin
			lat_f = lat_w + PI_ANGLE;
		end else begin
			lat_f = lat_w;
			lat_flip = 1'b0;
		end
	end

	// Input stage: start vectors for both rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_v[0] <= 1'b0;
		end else if (adv) begin
			sc_v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s[0].func     <= func;
			sc_s[0].flip_lon <= lon_flip;
			sc_s[0].flip_lat <= lat_flip;
			sc_s[0].lon_x    <= CORDIC_K;
			sc_s[0].lon_y    <= '0;
			sc_s[0].lon_z    <= lon_f;
			sc_s[0].lat_x    <= CORDIC_K;
			sc_s[0].lat_y    <= '0;
			sc_s[0].lat_z    <= lat_f;
		end
	end

	// CORDIC rotation chain, one micro-rotation per stage
	for (genvar j = 0; j < ITER; j++) begin : g_sc
		sc_data_t nx;

		always_comb begin
			nx = sc_s[j];
			if (sc_s[j].lon_z >= 0) begin
				nx.lon_x = sc_s[j].lon_x - (sc_s[j].lon_y >>> j);
				nx.lon_y = sc_s[j].lon_y + (sc_s[j].lon_x >>> j);
				nx.lon_z = sc_s[j].lon_z - atan_tab(j);
			end else begin
				nx.lon_x = sc_s[j].lon_x + (sc_s[j].lon_y >>> j);
				nx.lon_y = sc_s[j].lon_y - (sc_s[j].lon_x >>> j);
				nx.lon_z = sc_s[j].lon_z + atan_tab(j);
			end
			if (sc_s[j].lat_z >= 0) begin
				nx.lat_x = sc_s[j].lat_x - (sc_s[j].lat_y >>> j);
				nx.lat_y = sc_s[j].lat_y + (sc_s[j].lat_x >>> j);
				nx.lat_z = sc_s[j].lat_z - atan_tab(j);
			end else begin
				nx.lat_x = sc_s[j].lat_x + (sc_s[j].lat_y >>> j);
				nx.lat_y = sc_s[j].lat_y - (sc_s[j].lat_x >>> j);
				nx.lat_z = sc_s[j].lat_z + atan_tab(j);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sc_v[j+1] <= 1'b0;
			end else if (adv) begin
				sc_v[j+1] <= sc_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sc_s[j+1] <= nx;
			end
		end
	end

	// Undo the fold, then form products, then the unit vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sc_v[ITER];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= sc_s[ITER].func;
			clon_s1 <= sc_s[ITER].flip_lon ? -sc_s[ITER].lon_x : sc_s[ITER].lon_x;
			slon_s1 <= sc_s[ITER].flip_lon ? -sc_s[ITER].lon_y : sc_s[ITER].lon_y;
			clat_s1 <= sc_s[ITER].flip_lat ? -sc_s[ITER].lat_x : sc_s[ITER].lat_x;
			slat_s1 <= sc_s[ITER].flip_lat ? -sc_s[ITER].lat_y : sc_s[ITER].lat_y;

			func_s2 <= func_s1;
			px_s2   <= PW'(clon_s1) * PW'(clat_s1);
			py_s2   <= PW'(slon_s1) * PW'(clat_s1);
			slat_s2 <= slat_s1;

			func_s3 <= func_s2;
			xx_s3   <= px_s2[W+29:30];
			yy_s3   <= py_s2[W+29:30];
			zz_s3   <= slat_s2;
		end
	end

	// Face choice: greatest magnitude, z over y over x on a tie
	logic [W-1:0]        ax, ay, az;
	logic [2:0]          face_c;
	logic signed [W-1:0] sx_c, sy_c, sz_c;

	always_comb begin
		ax = xx_s3[W-1] ? W'(-xx_s3) : W'(xx_s3);
		ay = yy_s3[W-1] ? W'(-yy_s3) : W'(yy_s3);
		az = zz_s3[W-1] ? W'(-zz_s3) : W'(zz_s3);
		if (az >= ax && az >= ay) begin
			face_c = (zz_s3 > 0) ? FACE_PZ : FACE_NZ;
		end else if (ay >= ax) begin
			face_c = (yy_s3 > 0) ? FACE_PY : FACE_NY;
		end else begin
			face_c = (xx_s3 > 0) ? FACE_PX : FACE_NX;
		end
		case (face_c)
			FACE_PX: begin sx_c = yy_s3;  sy_c = zz_s3;  sz_c = xx_s3;  end
			FACE_PY: begin sx_c = -xx_s3; sy_c = zz_s3;  sz_c = yy_s3;  end
			FACE_NX: begin sx_c = -yy_s3; sy_c = zz_s3;  sz_c = -xx_s3; end
			FACE_NY: begin sx_c = xx_s3;  sy_c = zz_s3;  sz_c = -yy_s3; end
			FACE_PZ: begin sx_c = yy_s3;  sy_c = -xx_s3; sz_c = zz_s3;  end
			default: begin sx_c = yy_s3;  sy_c = xx_s3;  sz_c = -zz_s3; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s4 <= func_s3;
			face_s4 <= face_c;
			sx_s4   <= sx_c;
			sy_s4   <= sy_c;
			sz_s4   <= sz_c;
		end
	end

	// Divider set-up: magnitudes and signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			dv_v[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0].func   <= func_s4;
			dv_s[0].face   <= face_s4;
			dv_s[0].zero   <= !(sz_s4 > 0);
			dv_s[0].sx_neg <= sx_s4[W-1];
			dv_s[0].sy_neg <= sy_s4[W-1];
			dv_s[0].rx     <= RW'(sx_s4[W-1] ? W'(-sx_s4) : W'(sx_s4));
			dv_s[0].ry     <= RW'(sy_s4[W-1] ? W'(-sy_s4) : W'(sy_s4));
			dv_s[0].sz     <= RW'(sz_s4[W-1] ? W'(-sz_s4) : W'(sz_s4));
			dv_s[0].qx     <= '0;
			dv_s[0].qy     <= '0;
		end
	end

	// Restoring division, one quotient bit per stage, MSB first
	for (genvar j = 0; j < QB; j++) begin : g_dv
		dv_data_t nx;

		always_comb begin
			nx = dv_s[j];
			if (dv_s[j].rx >= dv_s[j].sz) begin
				nx.qx[QB-1-j] = 1'b1;
				nx.rx = (dv_s[j].rx - dv_s[j].sz) << 1;
			end else begin
				nx.rx = dv_s[j].rx << 1;
			end
			if (dv_s[j].ry >= dv_s[j].sz) begin
				nx.qy[QB-1-j] = 1'b1;
				nx.ry = (dv_s[j].ry - dv_s[j].sz) << 1;
			end else begin
				nx.ry = dv_s[j].ry << 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j+1] <= nx;
			end
		end
	end

	// Signed quotient, truncated toward zero; arctangent start vectors
	logic signed [W-1:0] gx_c, gy_c;

	always_comb begin
		if (dv_s[QB].zero) begin
			gx_c = '0;
			gy_c = '0;
		end else begin
			gx_c = dv_s[QB].sx_neg ? -W'(dv_s[QB].qx) : W'(dv_s[QB].qx);
			gy_c = dv_s[QB].sy_neg ? -W'(dv_s[QB].qy) : W'(dv_s[QB].qy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_v[0] <= 1'b0;
		end else if (adv) begin
			at_v[0] <= dv_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			at_s[0].func <= dv_s[QB].func;
			at_s[0].face <= dv_s[QB].face;
			at_s[0].gx   <= gx_c;
			at_s[0].gy   <= gy_c;
			at_s[0].ux   <= Q30_ONE;
			at_s[0].uy   <= gx_c;
			at_s[0].uz   <= '0;
			at_s[0].vx   <= Q30_ONE;
			at_s[0].vy   <= gy_c;
			at_s[0].vz   <= '0;
		end
	end

	// CORDIC vectoring chain for the equiangular angles
	for (genvar j = 0; j < ITER; j++) begin : g_at
		at_data_t nx;

		always_comb begin
			nx = at_s[j];
			if (at_s[j].uy >= 0) begin
				nx.ux = at_s[j].ux + (at_s[j].uy >>> j);
				nx.uy = at_s[j].uy - (at_s[j].ux >>> j);
				nx.uz = at_s[j].uz + atan_tab(j);
			end else begin
				nx.ux = at_s[j].ux - (at_s[j].uy >>> j);
				nx.uy = at_s[j].uy + (at_s[j].ux >>> j);
				nx.uz = at_s[j].uz - atan_tab(j);
			end
			if (at_s[j].vy >= 0) begin
				nx.vx = at_s[j].vx + (at_s[j].vy >>> j);
				nx.vy = at_s[j].vy - (at_s[j].vx >>> j);
				nx.vz = at_s[j].vz + atan_tab(j);
			end else begin
				nx.vx = at_s[j].vx - (at_s[j].vy >>> j);
				nx.vy = at_s[j].vy + (at_s[j].vx >>> j);
				nx.vz = at_s[j].vz - atan_tab(j);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				at_v[j+1] <= 1'b0;
			end else if (adv) begin
				at_v[j+1] <= at_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				at_s[j+1] <= nx;
			end
		end
	end

	// Result selection
	logic signed [31:0] res_cx, res_cy;

	assign res_cx = at_s[ITER].func ? at_s[ITER].uz[31:0] : at_s[ITER].gx[31:0];
	assign res_cy = at_s[ITER].func ? at_s[ITER].vz[31:0] : at_s[ITER].gy[31:0];

	// Output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_v_q) begin
				out_valid_q <= 1'b1;
				skid_v_q    <= 1'b0;
			end else begin
				out_valid_q <= at_v[ITER];
			end
		end else if (!skid_v_q && at_v[ITER]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_v_q) begin
				face_q <= skid_face_q;
				cx_q   <= skid_cx_q;
				cy_q   <= skid_cy_q;
			end else begin
				face_q <= at_s[ITER].face;
				cx_q   <= res_cx;
				cy_q   <= res_cy;
			end
		end else if (!skid_v_q) begin
			skid_face_q <= at_s[ITER].face;
			skid_cx_q   <= res_cx;
			skid_cy_q   <= res_cy;
		end
	end

	assign out_valid = out_valid_q;
	assign face      = face_q;
	assign coord_x   = cx_q;
	assign coord_y   = cy_q;

`ifndef NO_ASSERTIONS
	// Skid entry is only ever filled behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid_q)
		else $error("skid holds a result with no output result");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled while output was free");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> face_q <= FACE_NZ)
		else $error("face code out of range");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cx_q <= 32'sd1073741824 && cx_q >= -32'sd1073741824 &&
			cy_q <= 32'sd1073741824 && cy_q >= -32'sd1073741824))
		else $error("face coordinate beyond unit range");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Testbench for the cube face gnomonic projection unit: a directed table then
// random points, each result checked against a bit-exact CORDIC predictor.
// Depends on cfgp_pkg and cube_face_gnomonic_project_unit.
module testbench;
	import cfgp_pkg::*;

	localparam int  RANDOM_POINTS = 1430;
	localparam int  CYCLE_LIMIT   = 1000000;
	localparam int  DRAIN_CYCLES  = 200;
	localparam longint K_GAIN     = 64'sd652032874;
	localparam longint ONE_Q30    = 64'sd1073741824;

	// atan(2^-i) as binary angles; entries past 30 are zero
	localparam longint ATAN_STEP [0:30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
		5, 3, 1, 1};

	typedef struct {
		logic [2:0]         face;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
	} proj_t;

	typedef struct {
		bit                 f;
		int                 lon;
		int                 lat;
		bit                 face_known;
		logic [2:0]         face;
	} point_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               func = 1'b0;
	logic signed [31:0] longitude = '0;
	logic signed [31:0] latitude = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         face;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;

	// Face expectation travelling with the payload of directed rows
	logic               row_face_known = 1'b0;
	logic [2:0]         row_face = '0;

	proj_t  pending_proj[$];
	int     mismatches = 0;
	int     idle_mode = 0;
	logic   hold_off = 1'b0;

	cube_face_gnomonic_project_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .longitude(longitude), .latitude(latitude),
		.out_valid(out_valid), .out_stall(out_stall),
		.face(face), .coord_x(coord_x), .coord_y(coord_y)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// CORDIC rotation giving cosine and sine of a binary angle in Q2.30
	function automatic void rotate_angle(input longint a, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		bit flip;
		x = K_GAIN;
		y = 0;
		z = a;
		flip = 1'b0;
		if (z > ONE_Q30) begin
			z -= 2 * ONE_Q30;
			flip = 1'b1;
		end else if (z < -ONE_Q30) begin
			z += 2 * ONE_Q30;
			flip = 1'b1;
		end
		for (int i = 0; i < ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_STEP[i];
			end else begin
				x += dx; y -= dy; z += ATAN_STEP[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// CORDIC vectoring: arctangent of a Q2.30 ratio as a binary angle
	function automatic longint arctan_q30(input longint t);
		longint x, y, z, dx, dy;
		x = ONE_Q30;
		y = t;
		z = 0;
		for (int i = 0; i < ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_STEP[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_STEP[i];
			end
		end
		return z;
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// Face choice and gnomonic coordinates of one lon/lat point
	function automatic proj_t project_point(input logic f, input logic signed [31:0] lon,
			input logic signed [31:0] lat);
		longint clon, slon, clat, slat, vx, vy, vz, peak, tx, ty, nz, gx, gy;
		proj_t r;
		rotate_angle(longint'(lon), clon, slon);
		rotate_angle(longint'(lat), clat, slat);
		vx = (clon * clat) >>> 30;
		vy = (slon * clat) >>> 30;
		vz = slat;
		peak = mag(vx);
		if (mag(vy) > peak) peak = mag(vy);
		if (mag(vz) > peak) peak = mag(vz);
		// later axes win ties; a zero component picks the negative face
		r.face = FACE_PX;
		if (peak == mag(vx)) r.face = vx > 0 ? FACE_PX : FACE_NX;
		if (peak == mag(vy)) r.face = vy > 0 ? FACE_PY : FACE_NY;
		if (peak == mag(vz)) r.face = vz > 0 ? FACE_PZ : FACE_NZ;
		case (r.face)
			FACE_PX: begin tx = vy;  ty = vz;  nz = vx;  end
			FACE_PY: begin tx = -vx; ty = vz;  nz = vy;  end
			FACE_NX: begin tx = -vy; ty = vz;  nz = -vx; end
			FACE_NY: begin tx = vx;  ty = vz;  nz = -vy; end
			FACE_PZ: begin tx = vy;  ty = -vx; nz = vz;  end
			default: begin tx = vy;  ty = vx;  nz = -vz; end
		endcase
		if (nz > 0) begin
			gx = (tx * ONE_Q30) / nz;
			gy = (ty * ONE_Q30) / nz;
		end else begin
			gx = 0;
			gy = 0;
		end
		if (f) begin
			gx = arctan_q30(gx);
			gy = arctan_q30(gy);
		end
		r.cx = gx[31:0];
		r.cy = gy[31:0];
		return r;
	endfunction

	// Offer one point, idling first as the current mode asks
	task automatic offer_point(input point_row_t row);
		int idle_pct;
		idle_pct = (idle_mode == 0) ? 17 : (idle_mode == 1) ? 79 : 0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		func           <= row.f;
		longitude      <= row.lon;
		latitude       <= row.lat;
		row_face_known <= row.face_known;
		row_face       <= row.face;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_proj.size() != 0) @(posedge clk);
	endtask

	// Input side: predict every accepted transaction
	always @(posedge clk) begin
		proj_t p;
		if (arst_n && in_valid && !in_stall) begin
			p = project_point(func, longitude, latitude);
			if (row_face_known) p.face = row_face;
			pending_proj.push_back(p);
		end
	end

	// Output side: compare against the oldest prediction
	always @(posedge clk) begin
		proj_t p;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_proj.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: face %0d x %0d y %0d",
						face, coord_x, coord_y);
			end else begin
				p = pending_proj.pop_front();
				if (face !== p.face || coord_x !== p.cx || coord_y !== p.cy) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp face %0d x %0d y %0d, got face %0d x %0d y %0d",
							p.face, p.cx, p.cy, face, coord_x, coord_y);
				end
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		int idle_pct;
		idle_pct = (idle_mode == 0) ? 79 : (idle_mode == 1) ? 17 : 0;
		out_stall <= hold_off || ($urandom_range(99) < idle_pct);
	end

	// Long hold-off during the last random phase, where the sender never
	// idles, so the pipeline fills and stalls its input
	initial begin
		wait (idle_mode == 2);
		repeat (50) @(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		point_row_t dir_rows [$];
		point_row_t row;
		int lat_pick;
		// extremes, axis points, tie diagonals and out-of-range latitude
		dir_rows = '{
			'{0, 0, 0, 1, FACE_PX},
			'{1, 0, 0, 1, FACE_PX},
			'{0, 32'h4000_0000, 0, 1, FACE_PY},
			'{0, 32'hC000_0000, 0, 1, FACE_NY},
			'{0, 32'h8000_0000, 0, 1, FACE_NX},
			'{1, 32'h7FFF_FFFF, 0, 1, FACE_NX},
			'{0, 0, 32'h4000_0000, 1, FACE_PZ},
			'{1, 0, 32'hC000_0000, 1, FACE_NZ},
			'{0, 32'h2000_0000, 0, 0, 0},
			'{1, 32'hE000_0000, 0, 0, 0},
			'{0, 32'h6000_0000, 32'h1000_0000, 0, 0},
			'{1, 32'hA000_0000, 32'hF000_0000, 0, 0},
			'{0, 32'h2000_0000, 32'h1A00_0000, 0, 0},
			'{1, 32'h1234_5678, 32'h2000_0000, 0, 0},
			'{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0},
			'{1, 32'h8000_0000, 32'h8000_0000, 0, 0},
			'{0, 32'h0000_0001, 32'h5000_0000, 0, 0},
			'{1, 32'hFFFF_FFFF, 32'hB000_0000, 0, 0},
			'{0, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 0, 0},
			'{1, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0}};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) offer_point(dir_rows[i]);
		drain_results();

		// three random phases with different idling
		for (int m = 0; m < 3; m++) begin
			idle_mode = m;
			for (int n = 0; n < RANDOM_POINTS / 3; n++) begin
				row.f = $urandom_range(1);
				row.lon = $urandom;
				lat_pick = $urandom_range(9);
				if (lat_pick == 0)
					row.lat = $urandom;
				else if (lat_pick == 1)
					row.lat = ($urandom_range(1) ? 32'sd1073741824 : -32'sd1073741824)
						+ $signed($urandom_range(64)) - 32;
				else
					row.lat = $signed($urandom_range(32'h8000_0000)) - 32'sd1073741824;
				// bias some longitudes onto the axes and face diagonals
				if ($urandom_range(9) == 0)
					row.lon = {3'($urandom_range(7)), 29'h0}
						+ $signed($urandom_range(8)) - 4;
				row.face_known = 1'b0;
				row.face = '0;
				offer_point(row);
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_proj.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
